// ----- rtl/jfc_pkg.sv -----
// Package for the joint friction compensator: sizes, register indexes,
// reset values, the sequencer state type and the lane control struct.
// No dependencies; every other file of the block imports it.
package jfc_pkg;

  localparam int MAX_JOINTS          = 3;
  localparam int DEFAULT_JOINT_COUNT = 3;
  localparam int ANGLE_W             = 32;
  localparam int TORQUE_W            = 32;
  localparam int LANE_W              = 16;
  localparam int CFG_DATA_W          = 48;
  localparam int CFG_IDX_W           = 3;
  localparam int ITEM_W              = MAX_JOINTS * ANGLE_W;

  localparam logic [CFG_IDX_W-1:0] REG_VISC_POS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VISC_NEG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUL_POS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUL_NEG  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DB_SLOPE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DB_VEL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RATE      = 3'd7;

  localparam logic [LANE_W-1:0] SCALE_RESET = 16'd4096;
  localparam logic [LANE_W-1:0] RATE_RESET  = 16'd1000;

  // ceil(2^35 / 3); exact floor division by three for inputs below 2^33.
  localparam logic [33:0] DIV3_RECIP = 34'd11453246123;
  localparam int          DIV3_SHIFT = 35;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE,
    ST_SUM,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_REGION,
    ST_SCALE,
    ST_ROUND
  } jfc_state_t;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic en_rate;
    logic en_sum;
    logic en_div_lo;
    logic en_div_hi;
    logic en_region;
    logic en_scale;
    logic load_out;
  } jfc_ctrl_t;

endpackage

// ----- rtl/jfc_lane.sv -----
// One joint lane of the friction compensator: velocity, divide-by-three
// filter, three-region friction model, scaling and saturation.
// Depends on jfc_pkg; stepped by the enables from jfc_ctrl.
module jfc_lane import jfc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  jfc_ctrl_t           ctrl,
  input  logic [ANGLE_W-1:0]  angle,
  input  logic [LANE_W-1:0]   visc_pos,
  input  logic [LANE_W-1:0]   visc_neg,
  input  logic [LANE_W-1:0]   coul_pos,
  input  logic [LANE_W-1:0]   coul_neg,
  input  logic [LANE_W-1:0]   db_slope,
  input  logic [LANE_W-1:0]   db_vel,
  input  logic [LANE_W-1:0]   scale,
  input  logic [LANE_W-1:0]   rate,
  output logic [TORQUE_W-1:0] torque
);

  logic [31:0]        prev_angle;
  logic [31:0]        vel_recent;
  logic [31:0]        vel_older;
  logic signed [49:0] rate_prod;
  logic [32:0]        sum_mag;
  logic               sum_neg;
  logic [49:0]        div_lo;
  logic signed [31:0] vel;
  logic signed [48:0] t28;
  logic signed [53:0] scaled;

  logic signed [32:0] diff;
  logic signed [49:0] rate_prod_next;
  logic [31:0]        raw;
  logic signed [33:0] sum;
  logic [33:0]        sum_abs;
  logic [49:0]        div_lo_next;
  logic [49:0]        div_hi;
  logic [66:0]        quot_full;
  logic [31:0]        quot;
  logic [31:0]        vel_next;
  logic signed [32:0] vel_ext;
  logic signed [32:0] db_ext;
  logic               in_pos;
  logic               in_neg;
  logic signed [15:0] coef;
  logic [15:0]        offset;
  logic signed [48:0] offset_ext;
  logic signed [48:0] t28_next;
  logic signed [48:0] t28_rnd;
  logic signed [36:0] t16;
  logic signed [53:0] scaled_next;
  logic signed [53:0] scaled_rnd;
  logic [41:0]        res;

  assign diff           = $signed({angle[31], angle}) - $signed({prev_angle[31], prev_angle});
  assign rate_prod_next = diff * $signed({1'b0, rate});

  always_comb begin
    if ((&rate_prod[49:31]) || ~(|rate_prod[49:31])) begin
      raw = rate_prod[31:0];
    end else if (rate_prod[49]) begin
      raw = 32'h8000_0000;
    end else begin
      raw = 32'h7FFF_FFFF;
    end
  end

  assign sum = $signed({{2{raw[31]}}, raw}) + $signed({{2{vel_recent[31]}}, vel_recent})
             + $signed({{2{vel_older[31]}}, vel_older});
  assign sum_abs = sum[33] ? (34'd0 - sum) : sum;

  assign div_lo_next = sum_mag * DIV3_RECIP[16:0];
  assign div_hi      = sum_mag * DIV3_RECIP[33:17];
  assign quot_full   = {div_hi, 17'd0} + {17'd0, div_lo};
  assign quot        = quot_full[DIV3_SHIFT +: 32];
  assign vel_next    = sum_neg ? (32'd0 - quot) : quot;

  assign vel_ext = {vel[31], vel};
  assign db_ext  = $signed({13'd0, db_vel, 4'd0});
  assign in_pos  = vel_ext >= db_ext;
  assign in_neg  = vel_ext <= -db_ext;

  always_comb begin
    if (in_pos) begin
      coef   = $signed(visc_pos);
      offset = coul_pos;
    end else if (in_neg) begin
      coef   = $signed(visc_neg);
      offset = coul_neg;
    end else begin
      coef   = $signed(db_slope);
      offset = 16'd0;
    end
  end

  assign offset_ext  = $signed({{17{offset[15]}}, offset, 16'd0});
  assign t28_next    = coef * vel + offset_ext;
  assign t28_rnd     = t28 + 49'sd2048;
  assign t16         = t28_rnd[48:12];
  assign scaled_next = t16 * $signed({1'b0, scale});
  assign scaled_rnd  = scaled + 54'sd2048;
  assign res         = scaled_rnd[53:12];

  always_comb begin
    if ((&res[41:31]) || ~(|res[41:31])) begin
      torque = res[31:0];
    end else if (res[41]) begin
      torque = 32'h8000_0000;
    end else begin
      torque = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_angle <= '0;
      vel_recent <= '0;
      vel_older  <= '0;
    end else if (ctrl.en_div_hi) begin
      prev_angle <= angle;
      vel_older  <= vel_recent;
      vel_recent <= vel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_rate) begin
      rate_prod <= rate_prod_next;
    end
    if (ctrl.en_sum) begin
      sum_mag <= sum_abs[32:0];
      sum_neg <= sum[33];
    end
    if (ctrl.en_div_lo) begin
      div_lo <= div_lo_next;
    end
    if (ctrl.en_div_hi) begin
      vel <= $signed(vel_next);
    end
    if (ctrl.en_region) begin
      t28 <= t28_next;
    end
    if (ctrl.en_scale) begin
      scaled <= scaled_next;
    end
  end

endmodule

// ----- rtl/jfc_ctrl.sv -----
// Step sequencer of the friction compensator: walks every lane through
// its stages in lockstep and loads the shared output register.
// Depends on jfc_pkg.
module jfc_ctrl import jfc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_valid,
  input  logic      out_ready,
  output jfc_ctrl_t ctrl
);

  jfc_state_t state;
  jfc_state_t state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_RATE;
      ST_RATE:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_DIV_LO;
      ST_DIV_LO: state_next = ST_DIV_HI;
      ST_DIV_HI: state_next = ST_REGION;
      ST_REGION: state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_ROUND;
      ST_ROUND:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.capture  = in_valid;
      end
      ST_RATE:   ctrl.en_rate   = 1'b1;
      ST_SUM:    ctrl.en_sum    = 1'b1;
      ST_DIV_LO: ctrl.en_div_lo = 1'b1;
      ST_DIV_HI: ctrl.en_div_hi = 1'b1;
      ST_REGION: ctrl.en_region = 1'b1;
      ST_SCALE:  ctrl.en_scale  = 1'b1;
      ST_ROUND:  ctrl.load_out  = out_free;
      default:   ctrl = '0;
    endcase
  end

  a_capture_starts: assert property (@(posedge clk) disable iff (rst)
    ctrl.capture |=> state == ST_RATE)
    else $error("captured item did not start the velocity stage");

  a_state_update_once: assert property (@(posedge clk) disable iff (rst)
    ctrl.en_div_hi |=> state == ST_REGION && !ctrl.en_div_hi)
    else $error("lane state updated more than once for one item");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND && out_valid && !out_ready |=> state == ST_ROUND)
    else $error("result left the round stage while the output was blocked");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !ctrl.in_ready)
    else $error("input ready while an item is in progress");

endmodule

// ----- rtl/joint_friction_compensator.sv -----
// Top level of the joint friction compensator: configuration registers,
// input capture, one jfc_lane per joint and the merging output register.
// Depends on jfc_pkg, jfc_ctrl and jfc_lane.
//
//   Channel   Direction  Handshake                       Payload
//   s_axis    in         s_axis_tvalid / s_axis_tready   three joint angles, Q16.16
//   m_axis    out        m_axis_tvalid / m_axis_tready   three friction torques, Q16.16
//   cfg       in         cfg_valid / cfg_ready           cfg_index, cfg_data
//
// An item goes from acceptance to the result register through a capture step and seven
// lane stages (velocity product, filter sum, two halves of the
// divide-by-three product, region model, scaling, rounding).
// The lanes run in lockstep; one item is in flight at a time.
// A new item is accepted while the previous result still waits in the output
// register; the rounding stage holds until that register is free.
// Reset is synchronous and clears the filter state, the control logic and m_axis_tvalid.
module joint_friction_compensator import jfc_pkg::*; #(
  parameter int JOINT_COUNT = DEFAULT_JOINT_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // joint0_angle [31:0], joint1_angle [63:32], joint2_angle [95:64]
  input  logic [ITEM_W-1:0]     s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // joint0_torque [31:0], joint1_torque [63:32], joint2_torque [95:64]
  output logic [ITEM_W-1:0]     m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0] visc_pos;
  logic [CFG_DATA_W-1:0] visc_neg;
  logic [CFG_DATA_W-1:0] coul_pos;
  logic [CFG_DATA_W-1:0] coul_neg;
  logic [CFG_DATA_W-1:0] db_slope;
  logic [CFG_DATA_W-1:0] db_vel;
  logic [LANE_W-1:0]     scale;
  logic [LANE_W-1:0]     rate;
  logic [ITEM_W-1:0]     angles;
  logic [ITEM_W-1:0]     torques;
  jfc_ctrl_t             ctrl;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      visc_pos <= '0;
      visc_neg <= '0;
      coul_pos <= '0;
      coul_neg <= '0;
      db_slope <= '0;
      db_vel   <= '0;
      scale    <= SCALE_RESET;
      rate     <= RATE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VISC_POS: visc_pos <= cfg_data;
        REG_VISC_NEG: visc_neg <= cfg_data;
        REG_COUL_POS: coul_pos <= cfg_data;
        REG_COUL_NEG: coul_neg <= cfg_data;
        REG_DB_SLOPE: db_slope <= cfg_data;
        REG_DB_VEL:   db_vel   <= cfg_data;
        REG_SCALE:    scale    <= cfg_data[LANE_W-1:0];
        REG_RATE:     rate     <= cfg_data[LANE_W-1:0];
        default:      scale    <= scale;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      angles <= s_axis_tdata;
    end
  end

  jfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .ctrl      (ctrl)
  );

  for (genvar j = 0; j < MAX_JOINTS; j++) begin : g_lane
    if (j < JOINT_COUNT) begin : g_used
      jfc_lane u_lane (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .angle    (angles[j*ANGLE_W +: ANGLE_W]),
        .visc_pos (visc_pos[j*LANE_W +: LANE_W]),
        .visc_neg (visc_neg[j*LANE_W +: LANE_W]),
        .coul_pos (coul_pos[j*LANE_W +: LANE_W]),
        .coul_neg (coul_neg[j*LANE_W +: LANE_W]),
        .db_slope (db_slope[j*LANE_W +: LANE_W]),
        .db_vel   (db_vel[j*LANE_W +: LANE_W]),
        .scale    (scale),
        .rate     (rate),
        .torque   (torques[j*TORQUE_W +: TORQUE_W])
      );
    end else begin : g_unused
      assign torques[j*TORQUE_W +: TORQUE_W] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      m_axis_tdata <= torques;
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for joint_friction_compensator: a directed script and random
// register phases with angle trajectories, each result item checked against a predictor.
// Depends on jfc_pkg and the joint_friction_compensator RTL.
module tb;
  import jfc_pkg::*;

  localparam int JOINTS      = DEFAULT_JOINT_COUNT;
  localparam int REGS        = 1 << CFG_IDX_W;
  localparam int IDLE_LIMIT  = 3000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 12;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 75;
  localparam int QUIET_ITEMS = 50;
  localparam int SCRIPT_ROWS = 25;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef enum logic [2:0] {
    LANES_SMALL, LANES_NARROW, LANES_FULL, LANES_TOP, LANES_BOTTOM, LANES_ONES, LANES_ZERO
  } lane_mode_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [ITEM_W-1:0]     payload;
    logic                  typed;
    logic [ITEM_W-1:0]     torque;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ITEM_W-1:0]     s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [ITEM_W-1:0]     m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [CFG_DATA_W-1:0] coef [REGS];
  int                    last_angle [MAX_JOINTS];
  int                    vel_new [MAX_JOINTS];
  int                    vel_old [MAX_JOINTS];
  logic [ITEM_W-1:0]     torque_queue [$];
  int                    errors = 0;
  int                    idle_cycles = 0;
  int                    stall_left = 0;
  bit                    quiet = 1'b0;
  bit                    hold_req = 1'b0;
  bit                    hold_done = 1'b0;

  script_row_t script [SCRIPT_ROWS] = '{
    '{ROW_ITEM, REG_VISC_POS, {32'h0, 32'h0, 32'h0}, 1'b1, '0},
    '{ROW_CFG, REG_VISC_POS, 96'h02B8_03AE_02B8, 1'b0, '0},
    '{ROW_CFG, REG_VISC_NEG, 96'h0333_0400_0333, 1'b0, '0},
    '{ROW_CFG, REG_COUL_POS, 96'h088B_079D_05C3, 1'b0, '0},
    '{ROW_CFG, REG_COUL_NEG, 96'hF7B2_F7F3_FB49, 1'b0, '0},
    '{ROW_CFG, REG_DB_SLOPE, 96'h399A_399A_399A, 1'b0, '0},
    '{ROW_CFG, REG_DB_VEL, 96'h0, 1'b0, '0},
    // At rest with no deadband the positive Coulomb offset applies.
    '{ROW_ITEM, REG_VISC_POS, {32'h0, 32'h0, 32'h0}, 1'b1,
      {32'h0000_88B0, 32'h0000_79D0, 32'h0000_5C30}},
    '{ROW_CFG, REG_DB_VEL, 96'h00CD_00CD_019A, 1'b0, '0},
    '{ROW_ITEM, REG_VISC_POS, {32'sd2, -32'sd100, 32'sd100}, 1'b0, '0},
    '{ROW_ITEM, REG_VISC_POS, {32'sd4, -32'sd300, 32'sd300}, 1'b0, '0},
    '{ROW_ITEM, REG_VISC_POS, {32'sd6, -32'sd600, 32'sd600}, 1'b0, '0},
    '{ROW_ITEM, REG_VISC_POS, {32'sd6, -32'sd600, 32'sd600}, 1'b0, '0},
    '{ROW_ITEM, REG_VISC_POS, {32'h0, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0, '0},
    '{ROW_ITEM, REG_VISC_POS, {32'h0, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, '0},
    '{ROW_CFG, REG_RATE, 96'h0, 1'b0, '0},
    '{ROW_ITEM, REG_VISC_POS, {32'h4000_0000, -32'sd77, 32'sd123}, 1'b0, '0},
    '{ROW_ITEM, REG_VISC_POS, {32'h4000_0000, -32'sd77, 32'sd123}, 1'b0, '0},
    '{ROW_CFG, REG_RATE, 96'hFFFF, 1'b0, '0},
    '{ROW_CFG, REG_SCALE, 96'hFFFF, 1'b0, '0},
    '{ROW_CFG, REG_VISC_POS, 96'h7FFF_7FFF_7FFF, 1'b0, '0},
    '{ROW_CFG, REG_VISC_NEG, 96'h8000_8000_8000, 1'b0, '0},
    '{ROW_ITEM, REG_VISC_POS, {32'h0, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0, '0},
    '{ROW_ITEM, REG_VISC_POS, {32'h0, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, '0},
    '{ROW_ITEM, REG_VISC_POS, {32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF}, 1'b0, '0}
  };

  joint_friction_compensator #(
    .JOINT_COUNT(JOINTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint round_q12(input longint x);
    return (x + 2048) >>> 12;
  endfunction

  function automatic longint lane_s(input logic [CFG_DATA_W-1:0] w, input int j);
    return longint'($signed(w[LANE_W*j +: LANE_W]));
  endfunction

  function automatic logic [ITEM_W-1:0] predict_friction(input logic [ITEM_W-1:0] angles);
    logic [ITEM_W-1:0] torques;
    longint rate, scale, raw, vel, db, t28;
    int angle;
    int j;
    torques = '0;
    rate = longint'(coef[REG_RATE][LANE_W-1:0]);
    scale = longint'(coef[REG_SCALE][LANE_W-1:0]);
    for (j = 0; j < JOINTS; j++) begin
      angle = $signed(angles[ANGLE_W*j +: ANGLE_W]);
      raw = clamp32((longint'(angle) - longint'(last_angle[j])) * rate);
      vel = (raw + longint'(vel_new[j]) + longint'(vel_old[j])) / 3;
      db = longint'(coef[REG_DB_VEL][LANE_W*j +: LANE_W]) * 16;
      last_angle[j] = angle;
      vel_old[j] = vel_new[j];
      vel_new[j] = int'(vel);
      if (vel >= db)
        t28 = lane_s(coef[REG_VISC_POS], j) * vel + lane_s(coef[REG_COUL_POS], j) * 65536;
      else if (vel <= -db)
        t28 = lane_s(coef[REG_VISC_NEG], j) * vel + lane_s(coef[REG_COUL_NEG], j) * 65536;
      else
        t28 = lane_s(coef[REG_DB_SLOPE], j) * vel;
      torques[TORQUE_W*j +: TORQUE_W] =
        TORQUE_W'(clamp32(round_q12(round_q12(t28) * scale)));
    end
    return torques;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_lanes(input lane_mode_t mode);
    logic [CFG_DATA_W-1:0] w;
    int j;
    for (j = 0; j < MAX_JOINTS; j++) begin
      case (mode)
        LANES_SMALL:  w[LANE_W*j +: LANE_W] = 16'($urandom_range(0, 8191) - 4096);
        LANES_NARROW: w[LANE_W*j +: LANE_W] = 16'($urandom_range(0, 1024));
        LANES_FULL:   w[LANE_W*j +: LANE_W] = 16'($urandom);
        LANES_TOP:    w[LANE_W*j +: LANE_W] = 16'h7FFF;
        LANES_BOTTOM: w[LANE_W*j +: LANE_W] = 16'h8000;
        LANES_ONES:   w[LANE_W*j +: LANE_W] = 16'hFFFF;
        LANES_ZERO:   w[LANE_W*j +: LANE_W] = 16'h0000;
        default:      w[LANE_W*j +: LANE_W] = 16'h0000;
      endcase
    end
    return w;
  endfunction

  function automatic void check_torques(input logic [ITEM_W-1:0] got);
    logic [ITEM_W-1:0] want;
    int j;
    if (torque_queue.size() == 0) begin
      errors++;
      $display("%0t ns: result item with none expected: %h", $time, got);
      return;
    end
    want = torque_queue.pop_front();
    for (j = 0; j < MAX_JOINTS; j++) begin
      if (got[TORQUE_W*j +: TORQUE_W] !== want[TORQUE_W*j +: TORQUE_W]) begin
        errors++;
        $display("%0t ns: joint%0d torque expected %h, got %h", $time, j,
                 want[TORQUE_W*j +: TORQUE_W], got[TORQUE_W*j +: TORQUE_W]);
      end
    end
  endfunction

  task automatic send_angles(input logic [ITEM_W-1:0] angles, input logic typed,
                             input logic [ITEM_W-1:0] torque);
    logic [ITEM_W-1:0] want;
    s_axis_tdata <= angles;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    want = predict_friction(angles);
    torque_queue.push_back(typed ? torque : want);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (torque_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SCALE || idx == REG_RATE)
      coef[idx] = {{(CFG_DATA_W-LANE_W){1'b0}}, value[LANE_W-1:0]};
    else
      coef[idx] = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stall bursts, one long hold-off, none in the quiet tail.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_torques(m_axis_tdata);
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      stall_left = LONG_HOLD;
    end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17);
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("joint_friction_compensator test failed");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] phase_regs [REGS];
    int walk [MAX_JOINTS];
    int sel;
    int span;
    foreach (coef[i]) coef[i] = '0;
    coef[REG_SCALE] = {{(CFG_DATA_W-LANE_W){1'b0}}, SCALE_RESET};
    coef[REG_RATE] = {{(CFG_DATA_W-LANE_W){1'b0}}, RATE_RESET};
    foreach (walk[j]) walk[j] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (script[r].kind == ROW_CFG) begin
        if (s_axis_tvalid || torque_queue.size() != 0) drain;
        write_register(script[r].idx, script[r].payload[CFG_DATA_W-1:0]);
      end else begin
        send_angles(script[r].payload, script[r].typed, script[r].torque);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain;
      case (p)
        1: begin
          for (int r = 0; r <= REG_DB_SLOPE; r++) phase_regs[r] = random_lanes(LANES_TOP);
          phase_regs[REG_DB_VEL] = random_lanes(LANES_ZERO);
          phase_regs[REG_SCALE] = 48'hFFFF;
          phase_regs[REG_RATE] = 48'hFFFF;
        end
        2: begin
          for (int r = 0; r <= REG_DB_SLOPE; r++) phase_regs[r] = random_lanes(LANES_BOTTOM);
          phase_regs[REG_DB_VEL] = random_lanes(LANES_ONES);
          phase_regs[REG_SCALE] = 48'h0;
          phase_regs[REG_RATE] = 48'h1;
        end
        default: begin
          for (int r = 0; r <= REG_DB_SLOPE; r++) begin
            sel = $urandom_range(0, 9);
            phase_regs[r] = random_lanes(sel < 6 ? LANES_SMALL : sel < 8 ? LANES_FULL :
                                         sel == 8 ? LANES_TOP : LANES_BOTTOM);
          end
          sel = $urandom_range(0, 9);
          phase_regs[REG_DB_VEL] = random_lanes(sel < 7 ? LANES_NARROW :
                                                sel == 7 ? LANES_ZERO : LANES_FULL);
          phase_regs[REG_SCALE] = {32'($urandom), 16'($urandom_range(0, 8191))};
          phase_regs[REG_RATE] = {32'($urandom), 16'($urandom_range(1, 65535))};
          case ($urandom_range(0, 7))
            0, 1, 2: phase_regs[REG_RATE][LANE_W-1:0] = RATE_RESET;
            3:       phase_regs[REG_RATE][LANE_W-1:0] = 16'($urandom_range(1, 50));
            4:       phase_regs[REG_RATE][LANE_W-1:0] = 16'h0;
            default: ;
          endcase
        end
      endcase
      for (int r = 0; r < REGS; r++) write_register(CFG_IDX_W'(r), phase_regs[r]);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == PHASES - 1 && k >= PHASE_ITEMS - QUIET_ITEMS) quiet = 1'b1;
        if (p == 3 && k == 5) hold_req = 1'b1;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
          foreach (walk[j]) walk[j] = $urandom;
        end else if (sel > 2) begin
          case ($urandom_range(0, 3))
            0:       span = 8;
            1:       span = 300;
            2:       span = 20000;
            default: span = 1 << 24;
          endcase
          foreach (walk[j]) walk[j] += int'($urandom_range(0, 2 * span)) - span;
        end
        send_angles({walk[2], walk[1], walk[0]}, 1'b0, '0);
      end
    end

    drain;
    if (errors == 0)
      $display("joint_friction_compensator test passed");
    else
      $display("joint_friction_compensator test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/jfc_pkg.sv
rtl/jfc_lane.sv
rtl/jfc_ctrl.sv
rtl/joint_friction_compensator.sv
verif/tb.sv
